### sv/nsfc_pkg.sv
// shared constants, types and helper functions for the nmea sentence framer and checker
package nsfc_pkg;

    localparam logic [7:0] NO_DATA_BYTE     = 8'hFF;
    localparam logic [7:0] DOLLAR_BYTE      = 8'h24;
    localparam logic [7:0] CR_BYTE          = 8'h0D;
    localparam logic [7:0] STAR_BYTE        = 8'h2A;
    localparam logic [7:0] MAX_LENGTH_RESET = 8'd82;

    localparam logic [1:0] CAUSE_CR     = 2'd0;
    localparam logic [1:0] CAUSE_DOLLAR = 2'd1;
    localparam logic [1:0] CAUSE_LIMIT  = 2'd2;

    localparam logic [1:0] PHASE_BEFORE_STAR = 2'd0;
    localparam logic [1:0] PHASE_FIRST_DIGIT = 2'd1;
    localparam logic [1:0] PHASE_SECOND_DIGIT = 2'd2;
    localparam logic [1:0] PHASE_DIGITS_DONE = 2'd3;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_keep;
        logic       sentence_done;
        logic [1:0] end_cause;
        logic       checksum_ok;
        logic [7:0] sentence_length;
    } result_t;

    // bit 4 set means not an upper-case hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b0, c[3:0]};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    function automatic logic sum_matches(input logic [1:0] phase, input logic bad,
                                         input logic [7:0] xor_val, input logic [7:0] sum_val);
        return (phase == PHASE_DIGITS_DONE) && !bad && (xor_val == sum_val);
    endfunction

endpackage

### sv/nmea_sentence_framer_checker_top.sv
// path: a byte item is held in the input register, framed by the combinational logic and
// written to the result register; throughput: one byte item per cycle unless out_stall holds
// a waiting result item, since the framing logic between the two registers is combinational
// reset: asynchronous active low; clears the framing state, empties both
// registers and sets max_length to 82; no clearing pass
module nmea_sentence_framer_checker_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [7:0] wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] char_out,
    output logic       char_keep,
    output logic       sentence_done,
    output logic [1:0] end_cause,
    output logic       checksum_ok,
    output logic [7:0] sentence_length
);

    logic              advance;
    logic              fire;
    logic [7:0]        held_byte;
    nsfc_pkg::result_t result;
    nsfc_pkg::result_t out_item;

    nsfc_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .byte_in   (byte_in),
        .advance   (advance),
        .fire      (fire),
        .held_byte (held_byte)
    );

    nsfc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_data   (wr_data),
        .fire      (fire),
        .held_byte (held_byte),
        .result    (result)
    );

    nsfc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .result    (result),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    assign char_out        = out_item.char_out;
    assign char_keep       = out_item.char_keep;
    assign sentence_done   = out_item.sentence_done;
    assign end_cause       = out_item.end_cause;
    assign checksum_ok     = out_item.checksum_ok;
    assign sentence_length = out_item.sentence_length;

endmodule

### sv/nsfc_in_stage.sv
// input register holding one byte item ahead of the framing logic
module nsfc_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    input  logic       advance,
    output logic       fire,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    assign fire      = valid_reg && advance;
    assign in_stall  = valid_reg && !advance;
    assign take      = in_valid && !in_stall;
    assign held_byte = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= byte_in;
        end
    end

endmodule

### sv/nsfc_core.sv
// sentence framing state and checksum logic, one byte per cycle, taken only when fire is high
module nsfc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [7:0]        wr_data,
    input  logic              fire,
    input  logic [7:0]        held_byte,
    output nsfc_pkg::result_t result
);

    logic [7:0] max_length_reg;
    logic       in_sentence_reg;
    logic       in_sentence_next;
    logic [7:0] char_count_reg;
    logic [7:0] char_count_next;
    logic [7:0] running_xor_reg;
    logic [7:0] running_xor_next;
    logic [1:0] star_phase_reg;
    logic [1:0] star_phase_next;
    logic [7:0] received_sum_reg;
    logic [7:0] received_sum_next;
    logic       bad_digit_reg;
    logic       bad_digit_next;

    logic [7:0] lim;
    logic [7:0] count_inc;
    logic [4:0] digit;
    logic [7:0] ab_xor;
    logic [1:0] ab_phase;
    logic [7:0] ab_sum;
    logic       ab_bad;

    assign lim       = (max_length_reg == 8'd0) ? 8'd1 : max_length_reg;
    assign count_inc = char_count_reg + 8'd1;
    assign digit     = nsfc_pkg::hex_value(held_byte);

    // effect of absorbing the byte into the checksum fields
    always_comb
    begin
        ab_xor   = running_xor_reg;
        ab_phase = star_phase_reg;
        ab_sum   = received_sum_reg;
        ab_bad   = bad_digit_reg;
        unique case (star_phase_reg)
            nsfc_pkg::PHASE_BEFORE_STAR:
            begin
                if (held_byte == nsfc_pkg::STAR_BYTE)
                begin
                    ab_phase = nsfc_pkg::PHASE_FIRST_DIGIT;
                end
                else
                begin
                    ab_xor = running_xor_reg ^ held_byte;
                end
            end
            nsfc_pkg::PHASE_FIRST_DIGIT:
            begin
                if (digit[4])
                begin
                    ab_bad = 1'b1;
                end
                else
                begin
                    ab_sum = {digit[3:0], 4'h0};
                end
                ab_phase = nsfc_pkg::PHASE_SECOND_DIGIT;
            end
            nsfc_pkg::PHASE_SECOND_DIGIT:
            begin
                if (digit[4])
                begin
                    ab_bad = 1'b1;
                end
                else
                begin
                    ab_sum = {received_sum_reg[7:4], digit[3:0]};
                end
                ab_phase = nsfc_pkg::PHASE_DIGITS_DONE;
            end
            default:
            begin
                ab_phase = star_phase_reg;
            end
        endcase
    end

    always_comb
    begin
        in_sentence_next  = in_sentence_reg;
        char_count_next   = char_count_reg;
        running_xor_next  = running_xor_reg;
        star_phase_next   = star_phase_reg;
        received_sum_next = received_sum_reg;
        bad_digit_next    = bad_digit_reg;

        result                 = '0;
        result.char_out        = held_byte;

        if (held_byte != nsfc_pkg::NO_DATA_BYTE)
        begin
            if (!in_sentence_reg)
            begin
                if (held_byte == nsfc_pkg::DOLLAR_BYTE)
                begin
                    result.char_keep  = 1'b1;
                    in_sentence_next  = 1'b1;
                    char_count_next   = 8'd1;
                    running_xor_next  = 8'd0;
                    star_phase_next   = nsfc_pkg::PHASE_BEFORE_STAR;
                    received_sum_next = 8'd0;
                    bad_digit_next    = 1'b0;
                end
            end
            else if (held_byte == nsfc_pkg::CR_BYTE)
            begin
                result.sentence_done   = 1'b1;
                result.end_cause       = nsfc_pkg::CAUSE_CR;
                result.checksum_ok     = nsfc_pkg::sum_matches(star_phase_reg, bad_digit_reg,
                                                               running_xor_reg, received_sum_reg);
                result.sentence_length = char_count_reg;
                in_sentence_next       = 1'b0;
            end
            else if (held_byte == nsfc_pkg::DOLLAR_BYTE)
            begin
                result.sentence_done   = 1'b1;
                result.end_cause       = nsfc_pkg::CAUSE_DOLLAR;
                result.checksum_ok     = nsfc_pkg::sum_matches(star_phase_reg, bad_digit_reg,
                                                               running_xor_reg, received_sum_reg);
                result.sentence_length = char_count_reg;
                result.char_keep       = 1'b1;
                char_count_next        = 8'd1;
                running_xor_next       = 8'd0;
                star_phase_next        = nsfc_pkg::PHASE_BEFORE_STAR;
                received_sum_next      = 8'd0;
                bad_digit_next         = 1'b0;
            end
            else if (char_count_reg >= lim)
            begin
                // limit already reached by the dollar alone: this byte closes it unkept
                result.sentence_done   = 1'b1;
                result.end_cause       = nsfc_pkg::CAUSE_LIMIT;
                result.checksum_ok     = nsfc_pkg::sum_matches(star_phase_reg, bad_digit_reg,
                                                               running_xor_reg, received_sum_reg);
                result.sentence_length = char_count_reg;
                in_sentence_next       = 1'b0;
            end
            else
            begin
                result.char_keep  = 1'b1;
                char_count_next   = count_inc;
                running_xor_next  = ab_xor;
                star_phase_next   = ab_phase;
                received_sum_next = ab_sum;
                bad_digit_next    = ab_bad;
                if (count_inc >= lim)
                begin
                    result.sentence_done   = 1'b1;
                    result.end_cause       = nsfc_pkg::CAUSE_LIMIT;
                    result.checksum_ok     = nsfc_pkg::sum_matches(ab_phase, ab_bad,
                                                                   ab_xor, ab_sum);
                    result.sentence_length = count_inc;
                    in_sentence_next       = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg   <= nsfc_pkg::MAX_LENGTH_RESET;
            in_sentence_reg  <= 1'b0;
            char_count_reg   <= 8'd0;
            running_xor_reg  <= 8'd0;
            star_phase_reg   <= nsfc_pkg::PHASE_BEFORE_STAR;
            received_sum_reg <= 8'd0;
            bad_digit_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                max_length_reg <= wr_data;
            end
            if (fire)
            begin
                in_sentence_reg  <= in_sentence_next;
                char_count_reg   <= char_count_next;
                running_xor_reg  <= running_xor_next;
                star_phase_reg   <= star_phase_next;
                received_sum_reg <= received_sum_next;
                bad_digit_reg    <= bad_digit_next;
            end
        end
    end

    // a no-data item leaves the framing state untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && held_byte == nsfc_pkg::NO_DATA_BYTE) |=>
            ($stable(in_sentence_reg) && $stable(char_count_reg) && $stable(running_xor_reg)))
        else $error("no-data item changed framing state");

    // an open sentence always holds at least its dollar
    assert property (@(posedge clk) disable iff (!rst_n)
        in_sentence_reg |-> (char_count_reg != 8'd0))
        else $error("open sentence with zero count");

    // a result that ends nothing carries no cause, check or length
    assert property (@(posedge clk) disable iff (!rst_n)
        !result.sentence_done |->
            (result.end_cause == nsfc_pkg::CAUSE_CR && !result.checksum_ok
             && result.sentence_length == 8'd0))
        else $error("sentence fields set without sentence end");

    // a dollar inside a sentence both ends it and reopens one
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_sentence_reg && held_byte == nsfc_pkg::DOLLAR_BYTE) |=>
            (in_sentence_reg && char_count_reg == 8'd1))
        else $error("dollar did not reopen sentence");

endmodule

### sv/nsfc_out_stage.sv
// result register presenting one item per cycle to the output channel while out_stall is low
module nsfc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  nsfc_pkg::result_t result,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_stall,
    output nsfc_pkg::result_t out_item
);

    logic              valid_reg;
    logic              valid_next;
    nsfc_pkg::result_t item_reg;

    // room when empty or when the held item leaves this cycle
    assign advance   = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            item_reg <= result;
        end
    end

endmodule

### tb/sv/tb_nsfc_scoreboard_pkg.sv
// scoreboard class: predicts the framer result for every byte item and checks the block output
`timescale 1ns / 100ps
package tb_nsfc_scoreboard_pkg;
    import nsfc_pkg::*;

    class sentence_scoreboard;
        logic [7:0] limit_reg;
        logic       open_flag;
        logic [7:0] kept;
        logic [7:0] xor_acc;
        logic [1:0] phase;
        logic [7:0] sum_rx;
        logic       digit_err;
        result_t    expected_results[$];
        int         n_bytes;
        int         n_errors;
        int         n_done;
        int         n_good;
        int         cause_seen[3];

        function new();
            limit_reg = MAX_LENGTH_RESET;
            open_flag = 1'b0;
            kept      = 8'd0;
            xor_acc   = 8'd0;
            phase     = PHASE_BEFORE_STAR;
            sum_rx    = 8'd0;
            digit_err = 1'b0;
            n_bytes   = 0;
            n_errors  = 0;
            n_done    = 0;
            n_good    = 0;
            foreach (cause_seen[i])
            begin
                cause_seen[i] = 0;
            end
        endfunction

        function void set_limit(logic [7:0] v);
            limit_reg = v;
        endfunction

        function int waiting();
            return expected_results.size();
        endfunction

        function void start_sentence();
            open_flag = 1'b1;
            kept      = 8'd1;
            xor_acc   = 8'd0;
            phase     = PHASE_BEFORE_STAR;
            sum_rx    = 8'd0;
            digit_err = 1'b0;
        endfunction

        function logic is_hex(logic [7:0] c);
            return (c >= "0" && c <= "9") || (c >= "A" && c <= "F");
        endfunction

        function logic [3:0] nibble_of(logic [7:0] c);
            logic [7:0] d;
            d = (c <= "9") ? c - "0" : c - "A" + 8'd10;
            return d[3:0];
        endfunction

        function void take_char(logic [7:0] c);
            case (phase)
                PHASE_BEFORE_STAR:
                begin
                    if (c == STAR_BYTE)
                        phase = PHASE_FIRST_DIGIT;
                    else
                        xor_acc = xor_acc ^ c;
                end
                PHASE_FIRST_DIGIT:
                begin
                    if (!is_hex(c))
                        digit_err = 1'b1;
                    else
                        sum_rx = {nibble_of(c), 4'h0};
                    phase = PHASE_SECOND_DIGIT;
                end
                PHASE_SECOND_DIGIT:
                begin
                    if (!is_hex(c))
                        digit_err = 1'b1;
                    else
                        sum_rx[3:0] = nibble_of(c);
                    phase = PHASE_DIGITS_DONE;
                end
                default:
                begin
                end
            endcase
        endfunction

        function result_t closed(result_t r, logic [1:0] cause);
            r.sentence_done   = 1'b1;
            r.end_cause       = cause;
            r.checksum_ok     = (phase == PHASE_DIGITS_DONE) && !digit_err && (xor_acc == sum_rx);
            r.sentence_length = kept;
            n_done++;
            cause_seen[cause]++;
            if (r.checksum_ok)
                n_good++;
            return r;
        endfunction

        // note an accepted byte item and queue the result it must produce
        function void frame_byte(logic [7:0] b);
            result_t    r;
            logic [7:0] lim;
            r          = '0;
            r.char_out = b;
            lim        = (limit_reg == 8'd0) ? 8'd1 : limit_reg;
            n_bytes++;
            if (b != NO_DATA_BYTE)
            begin
                if (!open_flag)
                begin
                    if (b == DOLLAR_BYTE)
                    begin
                        start_sentence();
                        r.char_keep = 1'b1;
                    end
                end
                else if (b == CR_BYTE)
                begin
                    r         = closed(r, CAUSE_CR);
                    open_flag = 1'b0;
                end
                else if (b == DOLLAR_BYTE)
                begin
                    r = closed(r, CAUSE_DOLLAR);
                    start_sentence();
                    r.char_keep = 1'b1;
                end
                else if (kept >= lim)
                begin
                    // limit already met by the dollar alone: this byte closes it unkept
                    r         = closed(r, CAUSE_LIMIT);
                    open_flag = 1'b0;
                end
                else
                begin
                    r.char_keep = 1'b1;
                    kept        = kept + 8'd1;
                    take_char(b);
                    if (kept >= lim)
                    begin
                        r         = closed(r, CAUSE_LIMIT);
                        open_flag = 1'b0;
                    end
                end
            end
            expected_results.push_back(r);
        endfunction

        function void report_field(string field, logic [7:0] want, logic [7:0] got);
            if (n_errors < 30)
                $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            n_errors++;
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                if (n_errors < 30)
                    $display("%0t: result item with none expected, %s %0h",
                             $time, "expected nothing actual char_out", got.char_out);
                n_errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.char_out !== want.char_out)
                report_field("char_out", want.char_out, got.char_out);
            if (got.char_keep !== want.char_keep)
                report_field("char_keep", 8'(want.char_keep), 8'(got.char_keep));
            if (got.sentence_done !== want.sentence_done)
                report_field("sentence_done", 8'(want.sentence_done), 8'(got.sentence_done));
            if (got.end_cause !== want.end_cause)
                report_field("end_cause", 8'(want.end_cause), 8'(got.end_cause));
            if (got.checksum_ok !== want.checksum_ok)
                report_field("checksum_ok", 8'(want.checksum_ok), 8'(got.checksum_ok));
            if (got.sentence_length !== want.sentence_length)
                report_field("sentence_length", want.sentence_length, got.sentence_length);
        endfunction
    endclass

endpackage

### tb/sv/tb_nmea_sentence_framer_checker_top.sv
// testbench top: drives byte items with random gaps and stalls and checks every result item
`timescale 1ns / 100ps
module tb_nmea_sentence_framer_checker_top;
    import nsfc_pkg::*;
    import tb_nsfc_scoreboard_pkg::*;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       wr_en     = 1'b0;
    logic [7:0] wr_data   = 8'd0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] byte_in   = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] char_out;
    logic       char_keep;
    logic       sentence_done;
    logic [1:0] end_cause;
    logic       checksum_ok;
    logic [7:0] sentence_length;

    sentence_scoreboard sb = new();

    int gap_pct   = 0;
    int stall_pct = 0;
    int hold_req  = 0;
    int n_sent    = 0;

    nmea_sentence_framer_checker_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_en           (wr_en),
        .wr_data         (wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .byte_in         (byte_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .char_out        (char_out),
        .char_keep       (char_keep),
        .sentence_done   (sentence_done),
        .end_cause       (end_cause),
        .checksum_ok     (checksum_ok),
        .sentence_length (sentence_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // mostly short idle runs, now and then a long one
    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
    endfunction

    function automatic logic [7:0] body_char();
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'h7E));
        if ($urandom_range(0, 15) == 0)
            c = 8'($urandom_range(0, 255));
        else if ($urandom_range(0, 4) == 0)
            c = ",";
        else if (c == DOLLAR_BYTE || c == STAR_BYTE)
            c = ".";
        return c;
    endfunction

    function automatic logic [7:0] bad_digit_char();
        logic [7:0] c;
        case ($urandom_range(0, 2))
            0: c = 8'("a" + $urandom_range(0, 5));
            1: c = 8'("G" + $urandom_range(0, 19));
            default: c = 8'(":" + $urandom_range(0, 6));
        endcase
        return c;
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0)
            c = NO_DATA_BYTE;
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < gap_pct)
            gap = pick_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.frame_byte(b);
        n_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // one sentence with a random body, mostly a correct checksum, sometimes broken
    task automatic send_sentence(input int body);
        logic [7:0] sum;
        logic [7:0] c;
        logic [7:0] flip;
        int         kind;
        int         ending;
        sum = 8'h00;
        send_byte(DOLLAR_BYTE);
        for (int i = 0; i < body; i++)
        begin
            c   = body_char();
            sum = sum ^ c;
            send_byte(c);
            if ($urandom_range(0, 39) == 0)
                send_byte(NO_DATA_BYTE);
        end
        kind = $urandom_range(0, 19);
        if (kind < 19)
            send_byte(STAR_BYTE);
        if (kind < 16)
        begin
            if (kind >= 14)
            begin
                flip = 8'($urandom_range(1, 255));
                sum  = sum ^ flip;
            end
            send_byte(hex_char(sum[7:4]));
            send_byte(hex_char(sum[3:0]));
        end
        else if (kind < 18)
        begin
            if ($urandom_range(0, 1))
            begin
                send_byte(bad_digit_char());
                send_byte(hex_char(sum[3:0]));
            end
            else
            begin
                send_byte(hex_char(sum[7:4]));
                send_byte(bad_digit_char());
            end
        end
        else if (kind == 18)
        begin
            send_byte(hex_char(sum[7:4]));
        end
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) send_byte(body_char());
        ending = $urandom_range(0, 9);
        if (ending < 7)
            send_byte(CR_BYTE);
        else if (ending == 9)
            send_byte(noise_byte());
    endtask

    task automatic write_limit(input logic [7:0] v);
        in_valid <= 1'b0;
        while (sb.waiting() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        wr_en   <= 1'b1;
        wr_data <= v;
        @(posedge clk);
        wr_en <= 1'b0;
        sb.set_limit(v);
    endtask

    task automatic run_phase(input int lim, input int budget);
        int start;
        int body;
        start = n_sent;
        if (lim > 12)
        begin
            // aim around the limit so it is hit exactly, just missed, or passed
            body = lim + int'($urandom_range(0, 3)) - 2;
            send_sentence(body);
        end
        while (n_sent - start < budget)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                body = int'($urandom_range(0, 12));
                send_sentence(body);
            end
            else
            begin
                repeat ($urandom_range(1, 4)) send_byte(noise_byte());
            end
        end
    endtask

    function automatic int limit_for(input int p);
        case (p)
            0: return 1;
            1: return 254;
            2: return 6;
            3: return 20;
            4: return 2;
            5: return 40;
            6: return $urandom_range(3, 30);
            default: return 12;
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0: return 5;
            1: return 20;
            default: return 50;
        endcase
    endfunction

    // receiver: checks accepted result items and decides the stall for the next edge
    initial
    begin
        result_t got;
        int      stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.char_out        = char_out;
                got.char_keep       = char_keep;
                got.sentence_done   = sentence_done;
                got.end_cause       = end_cause;
                got.checksum_ok     = checksum_ok;
                got.sentence_length = sentence_length;
                sb.check_result(got);
            end
            if (hold_req > 0)
            begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            else if (stall_left == 0 && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = pick_len();
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int lim;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed bytes at the reset limit
        gap_pct   = 20;
        stall_pct = 20;
        send_byte(NO_DATA_BYTE);
        send_byte(8'h00);
        send_byte(8'h80);
        send_text("$A,");
        send_byte(NO_DATA_BYTE);
        send_text("*6Dx");
        send_byte(CR_BYTE);
        send_text("$*00$C*4c");
        send_byte(CR_BYTE);
        send_text("$N");
        send_byte(CR_BYTE);
        send_byte(8'h7F);

        for (int p = 0; p < 8; p++)
        begin
            lim = limit_for(p);
            write_limit(8'(lim));
            if (p == 0)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else if (p == 3)
            begin
                // receiver holds off while the sender keeps offering items
                gap_pct   = 0;
                stall_pct = 10;
                hold_req  = 60;
            end
            else
            begin
                gap_pct   = pick_pct();
                stall_pct = pick_pct();
            end
            run_phase(lim, 12);
        end

        in_valid <= 1'b0;
        while (sb.waiting() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d byte items over 9 limit settings, %0d sentences closed",
                 sb.n_bytes, sb.n_done);
        $display("%0d with good checksum; closed by carriage return %0d, %s %0d, %s %0d",
                 sb.n_good, sb.cause_seen[CAUSE_CR], "by new dollar", sb.cause_seen[CAUSE_DOLLAR],
                 "by length limit", sb.cause_seen[CAUSE_LIMIT]);
        if (sb.n_errors == 0)
            $display("nmea_sentence_framer_checker_top: match");
        else
            $display("nmea_sentence_framer_checker_top: mismatch");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("timeout with %0d result items outstanding", sb.waiting());
        $display("nmea_sentence_framer_checker_top: mismatch");
        $finish;
    end

endmodule

### sim.f
sv/nsfc_pkg.sv
sv/nsfc_in_stage.sv
sv/nsfc_core.sv
sv/nsfc_out_stage.sv
sv/nmea_sentence_framer_checker_top.sv
tb/sv/tb_nsfc_scoreboard_pkg.sv
tb/sv/tb_nmea_sentence_framer_checker_top.sv
